>>> hdl/d2mf_pkg.sv
// ----------------------------------------------------------------------------
// d2mf_pkg
// Shared types and constants for the binary64 to minifloat converter.
// ----------------------------------------------------------------------------
package d2mf_pkg;

    localparam int IN_WIDTH   = 64;
    localparam int OUT_WIDTH  = 32;
    localparam int EW_WIDTH   = 4;
    localparam int MW_WIDTH   = 5;
    localparam int ADDR_WIDTH = 3;

    localparam logic [EW_WIDTH-1:0] EW_RESET = 4'd8;
    localparam logic [MW_WIDTH-1:0] MW_RESET = 5'd23;
    localparam logic [EW_WIDTH-1:0] EW_MIN   = 4'd2;
    localparam logic [EW_WIDTH-1:0] EW_MAX   = 4'd8;
    localparam logic [MW_WIDTH-1:0] MW_MIN   = 5'd1;
    localparam logic [MW_WIDTH-1:0] MW_MAX   = 5'd23;

    localparam logic [ADDR_WIDTH-1:0] ADDR_EXP_WIDTH = 3'd0;
    localparam logic [ADDR_WIDTH-1:0] ADDR_MAN_WIDTH = 3'd4;

    // Result class decided in the first stage; stage 2 turns an overflowing number into infinity.
    typedef enum logic [2:0] {
        CLS_NUM  = 3'd0,
        CLS_NAN  = 3'd1,
        CLS_INF  = 3'd2,
        CLS_ZERO = 3'd3
    } cls_t;

endpackage

>>> hdl/d2mf_stream_if.sv
// ----------------------------------------------------------------------------
// d2mf_stream_if
// Valid/ready channel carrying one data word.
// ----------------------------------------------------------------------------
interface d2mf_stream_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/double_to_minifloat_converter.sv
// ----------------------------------------------------------------------------
// double_to_minifloat_converter
// Converts binary64 words into a register-configured minifloat format.
// ----------------------------------------------------------------------------
// Usage: binary64 words arrive on the in_ch sink channel and converted words
// leave on the out_ch source channel, one result word for every input word.
// Both channels use a valid/ready handshake.
// The format is set through the APB port: exponent width at address 0 and
// mantissa width at address 4. Write them only while the pipeline is empty.
// A word accepted on in_ch passes through the stage registers s1 to s4 and is
// shown on out_ch from s4. The block accepts one word every cycle while the
// receiver does not stall, since all four stages move together.
// When the receiver stalls, the whole pipeline holds in place, and in_ch is
// ready exactly when the last stage is empty or is being taken. Nothing is
// dropped or repeated.
// Reset clears all stage valid bits and loads exponent width 8 and mantissa
// width 23, which gives the binary32 layout.
// ----------------------------------------------------------------------------
module double_to_minifloat_converter
(
    input  logic                                clk,
    input  logic                                rst_n,
    d2mf_stream_if.sink                         in_ch,
    d2mf_stream_if.source                       out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [d2mf_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [d2mf_pkg::EW_WIDTH-1:0] exp_width_reg;
    logic [d2mf_pkg::MW_WIDTH-1:0] man_width_reg;
    logic advance;
    logic core_valid;

    assign pready = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_width_reg <= d2mf_pkg::EW_RESET;
            man_width_reg <= d2mf_pkg::MW_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == d2mf_pkg::ADDR_EXP_WIDTH)
                exp_width_reg <= pwdata[d2mf_pkg::EW_WIDTH-1:0];
            else if (paddr == d2mf_pkg::ADDR_MAN_WIDTH)
                man_width_reg <= pwdata[d2mf_pkg::MW_WIDTH-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            d2mf_pkg::ADDR_EXP_WIDTH: prdata = {28'd0, exp_width_reg};
            d2mf_pkg::ADDR_MAN_WIDTH: prdata = {27'd0, man_width_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // The pipeline moves whenever the final stage is free or being taken.
    assign advance     = !core_valid || out_ch.ready;
    assign in_ch.ready = advance;
    assign out_ch.valid = core_valid;

    d2mf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_ch.valid),
        .in_value  (in_ch.data),
        .exp_width (exp_width_reg),
        .man_width (man_width_reg),
        .out_valid (core_valid),
        .out_word  (out_ch.data)
    );

endmodule

>>> hdl/d2mf_core.sv
// ----------------------------------------------------------------------------
// d2mf_core
// Four stage conversion pipeline with a shared stall enable.
// ----------------------------------------------------------------------------
module d2mf_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [d2mf_pkg::IN_WIDTH-1:0]     in_value,
    input  logic [d2mf_pkg::EW_WIDTH-1:0]     exp_width,
    input  logic [d2mf_pkg::MW_WIDTH-1:0]     man_width,
    output logic                              out_valid,
    output logic [d2mf_pkg::OUT_WIDTH-1:0]    out_word
);

    // Stage 1: classify, normalize significand to bit 52, clamp widths.
    logic        s1_valid_reg;
    logic        s1_sign_reg;
    d2mf_pkg::cls_t s1_cls_reg;
    logic [52:0] s1_sig_reg;
    logic signed [12:0] s1_x_reg;
    logic [3:0]  s1_e_reg;
    logic [4:0]  s1_m_reg;

    logic [10:0] bexp;
    logic [51:0] frac;
    logic [5:0]  lz;
    logic        found;
    logic [3:0]  e_c;
    logic [4:0]  m_c;
    d2mf_pkg::cls_t cls_next;
    logic [52:0] sig_next;
    logic signed [12:0] x_next;

    always_comb
    begin
        bexp = in_value[62:52];
        frac = in_value[51:0];
        lz = 6'd0;
        found = 1'b0;
        for (int i = 51; i >= 0; i--)
        begin
            if (!found && frac[i])
            begin
                found = 1'b1;
                lz = 6'(51 - i);
            end
        end
        e_c = (exp_width < d2mf_pkg::EW_MIN) ? d2mf_pkg::EW_MIN :
              (exp_width > d2mf_pkg::EW_MAX) ? d2mf_pkg::EW_MAX : exp_width;
        m_c = (man_width < d2mf_pkg::MW_MIN) ? d2mf_pkg::MW_MIN :
              (man_width > d2mf_pkg::MW_MAX) ? d2mf_pkg::MW_MAX : man_width;
        if (bexp == 11'h7FF)
            cls_next = (frac != 52'd0) ? d2mf_pkg::CLS_NAN : d2mf_pkg::CLS_INF;
        else if (bexp == 11'd0 && frac == 52'd0)
            cls_next = d2mf_pkg::CLS_ZERO;
        else
            cls_next = d2mf_pkg::CLS_NUM;
        if (bexp != 11'd0)
        begin
            sig_next = {1'b1, frac};
            x_next = $signed({2'b00, bexp}) - 13'sd1023;
        end
        else
        begin
            sig_next = {frac, 1'b0} << lz;
            x_next = -13'sd1023 - $signed({7'd0, lz});
        end
    end

    // Stage 2: overflow test and shift amount.
    logic        s2_valid_reg;
    logic        s2_sign_reg;
    d2mf_pkg::cls_t s2_cls_reg;
    logic [52:0] s2_sig_reg;
    logic [6:0]  s2_sh_reg;
    logic        s2_norm_reg;
    logic signed [12:0] s2_x_reg;
    logic [3:0]  s2_e_reg;
    logic [4:0]  s2_m_reg;

    logic signed [12:0] bias1;
    logic signed [12:0] emin1;
    logic [52:0] maxsig1;
    logic        ovf1;
    logic signed [13:0] shn1;
    logic [6:0]  sh1;

    always_comb
    begin
        bias1 = $signed(13'((13'd1 << (s1_e_reg - 4'd1)) - 13'd1));
        emin1 = 13'sd1 - bias1;
        maxsig1 = ((53'd1 << (s1_m_reg + 5'd1)) - 53'd1) << (6'd52 - {1'b0, s1_m_reg});
        ovf1 = (s1_x_reg > bias1) || (s1_x_reg == bias1 && s1_sig_reg > maxsig1);
        if (s1_x_reg >= emin1)
            shn1 = 14'sd52 - $signed({9'd0, s1_m_reg});
        else
            shn1 = 14'sd52 - $signed({9'd0, s1_m_reg}) + 14'(emin1) - 14'(s1_x_reg);
        sh1 = (shn1 > 14'sd64) ? 7'd64 : 7'(shn1);
    end

    // Stage 3: round to nearest even.
    logic        s3_valid_reg;
    logic        s3_sign_reg;
    d2mf_pkg::cls_t s3_cls_reg;
    logic [53:0] s3_q_reg;
    logic        s3_norm_reg;
    logic signed [12:0] s3_x_reg;
    logic [3:0]  s3_e_reg;
    logic [4:0]  s3_m_reg;

    logic [52:0] q2;
    logic [63:0] mask2;
    logic [63:0] rem2;
    logic [63:0] half2;
    logic [53:0] qr2;

    always_comb
    begin
        if (s2_sh_reg >= 7'd64)
        begin
            q2 = 53'd0;
            mask2 = '1;
            half2 = 64'd1 << 63;
        end
        else
        begin
            q2 = s2_sig_reg >> s2_sh_reg;
            mask2 = (64'd1 << s2_sh_reg[5:0]) - 64'd1;
            half2 = 64'd1 << (s2_sh_reg[5:0] - 6'd1);
        end
        rem2 = {11'd0, s2_sig_reg} & mask2;
        qr2 = {1'b0, q2};
        if (rem2 > half2 || (rem2 == half2 && q2[0]))
            qr2 = qr2 + 54'd1;
    end

    // Stage 4: pack.
    logic        s4_valid_reg;
    logic [31:0] s4_word_reg;

    logic [31:0] word3;
    logic [31:0] maxexp3;
    logic signed [12:0] bias3;
    logic signed [12:0] biased3;
    logic [53:0] q3;
    logic [31:0] exf;
    logic [31:0] frf;
    logic        sg;

    always_comb
    begin
        maxexp3 = (32'd1 << s3_e_reg) - 32'd1;
        bias3 = $signed(13'((13'd1 << (s3_e_reg - 4'd1)) - 13'd1));
        q3 = s3_q_reg;
        biased3 = s3_x_reg + bias3;
        sg = s3_sign_reg;
        exf = 32'd0;
        frf = 32'd0;
        case (s3_cls_reg)
            d2mf_pkg::CLS_NAN:
            begin
                sg = 1'b0;
                exf = maxexp3;
                frf = 32'd1;
            end
            d2mf_pkg::CLS_INF: exf = maxexp3;
            d2mf_pkg::CLS_ZERO: exf = 32'd0;
            default:
            begin
                if (s3_norm_reg)
                begin
                    if ((q3 >> (s3_m_reg + 5'd1)) != 54'd0)
                    begin
                        q3 = q3 >> 1;
                        biased3 = biased3 + 13'sd1;
                    end
                    if (biased3 >= $signed(13'(maxexp3)))
                        exf = maxexp3;
                    else
                    begin
                        exf = 32'(biased3);
                        frf = q3[31:0];
                    end
                end
                else if (q3 >= (54'd1 << s3_m_reg))
                    exf = 32'd1;
                else
                    frf = q3[31:0];
            end
        endcase
        word3 = ({31'd0, sg} << (s3_e_reg + s3_m_reg))
              | ((exf & maxexp3) << s3_m_reg)
              | (frf & ((32'd1 << s3_m_reg) - 32'd1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sign_reg <= in_value[63];
            s1_cls_reg  <= cls_next;
            s1_sig_reg  <= sig_next;
            s1_x_reg    <= x_next;
            s1_e_reg    <= e_c;
            s1_m_reg    <= m_c;

            s2_sign_reg <= s1_sign_reg;
            s2_cls_reg  <= (s1_cls_reg == d2mf_pkg::CLS_NUM && ovf1) ?
                           d2mf_pkg::CLS_INF : s1_cls_reg;
            s2_sig_reg  <= s1_sig_reg;
            s2_sh_reg   <= sh1;
            s2_norm_reg <= (s1_x_reg >= emin1);
            s2_x_reg    <= s1_x_reg;
            s2_e_reg    <= s1_e_reg;
            s2_m_reg    <= s1_m_reg;

            s3_sign_reg <= s2_sign_reg;
            s3_cls_reg  <= s2_cls_reg;
            s3_q_reg    <= qr2;
            s3_norm_reg <= s2_norm_reg;
            s3_x_reg    <= s2_x_reg;
            s3_e_reg    <= s2_e_reg;
            s3_m_reg    <= s2_m_reg;

            s4_word_reg <= word3;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_word  = s4_word_reg;

endmodule

>>> hdl/d2mf_checker.sv
// ----------------------------------------------------------------------------
// d2mf_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module d2mf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_data,
    input logic        pready
);

    // A waiting result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("stalled result changed");

    // Input is refused only while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without stall");

    // A word taken while the receiver never stalls later shows up as a valid result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
        |=> out_valid)
        else $error("result missing after latency");

    assert property (@(posedge clk) pready)
        else $error("pready dropped");

endmodule

bind double_to_minifloat_converter d2mf_checker u_d2mf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .pready    (pready)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the binary64 to minifloat converter.
// ----------------------------------------------------------------------------
// Each binary64 word handed to the converter goes through a behavioral
// conversion that is written here with exact integer rounding. The result is
// queued. The monitor checks every result word against the oldest queued
// value. The run covers several formats, the narrowest and widest among them,
// and both out-of-range register settings. The sender and the receiver idle
// at random, and one phase holds the receiver off long enough to fill the
// pipeline.
// ----------------------------------------------------------------------------
module tb_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [d2mf_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    d2mf_stream_if #(.WIDTH(d2mf_pkg::IN_WIDTH))  in_ch ();
    d2mf_stream_if #(.WIDTH(d2mf_pkg::OUT_WIDTH)) out_ch ();

    double_to_minifloat_converter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // The bench's own copy of the converter's format registers.
    logic [d2mf_pkg::EW_WIDTH-1:0] exp_bits_reg = d2mf_pkg::EW_RESET;
    logic [d2mf_pkg::MW_WIDTH-1:0] man_bits_reg = d2mf_pkg::MW_RESET;

    logic [d2mf_pkg::IN_WIDTH-1:0]  pending_words[$];
    logic [d2mf_pkg::OUT_WIDTH-1:0] expected_codes[$];

    int          error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          recv_hold = 1'b0;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    task automatic report_mismatch(input string what,
                                   input logic [d2mf_pkg::OUT_WIDTH-1:0] got,
                                   input logic [d2mf_pkg::OUT_WIDTH-1:0] want);
        error_count++;
        $display("mismatch: %s got %h expected %h", what, got, want);
    endtask

    // Shift right with round-to-nearest-even.
    function automatic logic [63:0] round_shift(input logic [63:0] v, input int sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (sh <= 0)
            return v;
        if (sh >= 64)
            return 64'd0;
        q = v >> sh;
        rem = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q++;
        return q;
    endfunction

    function automatic logic [d2mf_pkg::OUT_WIDTH-1:0] pack_code(input bit sgn, input int e,
                                                                 input int m,
                                                                 input int unsigned ex,
                                                                 input logic [63:0] fr);
        logic [31:0] r;
        r = (32'(sgn) << (e + m)) | ((32'(ex) & ((32'd1 << e) - 1)) << m)
            | (fr[31:0] & ((32'd1 << m) - 1));
        return r;
    endfunction

    // Converts one binary64 word into the format held in the registers.
    function automatic logic [d2mf_pkg::OUT_WIDTH-1:0] convert_double(input logic [63:0] v);
        bit          sgn;
        int          bexp;
        logic [63:0] frac;
        logic [63:0] sig;
        logic [63:0] maxsig;
        logic [63:0] q;
        int          e;
        int          m;
        int          maxexp;
        int          bias;
        int          emin;
        int          x;
        int          p;
        sgn = v[63];
        bexp = int'(v[62:52]);
        frac = {12'd0, v[51:0]};
        e = int'(exp_bits_reg);
        m = int'(man_bits_reg);
        // Out-of-range register values are saturated when used.
        if (e < 2) e = 2;
        if (e > 8) e = 8;
        if (m < 1) m = 1;
        if (m > 23) m = 23;
        maxexp = (1 << e) - 1;
        bias = (1 << (e - 1)) - 1;
        emin = 1 - bias;
        if (bexp == 2047)
        begin
            if (frac != 0)
                return pack_code(1'b0, e, m, maxexp, 64'd1);
            return pack_code(sgn, e, m, maxexp, 64'd0);
        end
        if (bexp == 0 && frac == 0)
            return pack_code(sgn, e, m, 0, 64'd0);
        if (bexp != 0)
        begin
            sig = frac | (64'd1 << 52);
            x = bexp - 1023;
        end
        else
        begin
            // Binary64 subnormal: normalize so the leading one sits at bit 52.
            p = 51;
            while (p > 0 && !frac[p])
                p--;
            sig = frac << (52 - p);
            x = p - 1074;
        end
        maxsig = ((64'd1 << (m + 1)) - 64'd1) << (52 - m);
        if (x > bias || (x == bias && sig > maxsig))
            return pack_code(sgn, e, m, maxexp, 64'd0);
        if (x >= emin)
        begin
            q = round_shift(sig, 52 - m);
            // A carry out of the mantissa bumps the exponent.
            if ((q >> (m + 1)) != 0)
            begin
                q = q >> 1;
                x++;
            end
            if (x + bias >= maxexp)
                return pack_code(sgn, e, m, maxexp, 64'd0);
            return pack_code(sgn, e, m, x + bias, q);
        end
        q = round_shift(sig, 52 - m + emin - x);
        if (q == 0)
            return pack_code(sgn, e, m, 0, 64'd0);
        if (q >= (64'd1 << m))
            return pack_code(sgn, e, m, 1, 64'd0);
        return pack_code(sgn, e, m, 0, q);
    endfunction

    // Driver: offers queued words, with random idle cycles.
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            expected_codes.push_back(convert_double(in_ch.data));
            void'(pending_words.pop_front());
        end
        if ((!in_ch.valid || in_ch.ready) )
        begin
            if (in_ch.valid && in_ch.ready && pending_words.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_words[0];
            end
            else if (!(in_ch.valid && in_ch.ready) && pending_words.size() > 0
                     && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_words[0];
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Monitor: checks result words and drives ready.
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            if (expected_codes.size() == 0)
                report_mismatch("unexpected word", out_ch.data, '0);
            else if (out_ch.data !== expected_codes[0])
                report_mismatch("encoded", out_ch.data, expected_codes.pop_front());
            else
                void'(expected_codes.pop_front());
        end
        out_ch.ready <= rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic apb_write(input logic [d2mf_pkg::ADDR_WIDTH-1:0] addr,
                             input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == d2mf_pkg::ADDR_EXP_WIDTH)
            exp_bits_reg = data[d2mf_pkg::EW_WIDTH-1:0];
        else
            man_bits_reg = data[d2mf_pkg::MW_WIDTH-1:0];
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_codes.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        int          bexp;
        w = {$urandom, $urandom};
        // Mostly exponents near the target range so every path is reached.
        case ($urandom_range(9))
            0, 1, 2, 3, 4: bexp = 1023 + $urandom_range(300) - 150;
            5: bexp = $urandom_range(2047);
            6: bexp = 0;
            7: bexp = 2047;
            default: bexp = 1023 + $urandom_range(260) - 130;
        endcase
        w[62:52] = bexp[10:0];
        // Sometimes put the word right on a rounding tie.
        if ($urandom_range(3) == 0)
            w[51:0] = w[51:0] & ~((52'd1 << $urandom_range(51)) - 52'd1)
                      | (52'd1 << $urandom_range(30));
        return w;
    endfunction

    // Directed words: extremes, zeros, infinities, NaNs, ties and carries.
    task automatic queue_directed();
        pending_words.push_back(64'h0000_0000_0000_0000);
        pending_words.push_back(64'h8000_0000_0000_0000);
        pending_words.push_back(64'h7FF0_0000_0000_0000);
        pending_words.push_back(64'hFFF0_0000_0000_0000);
        pending_words.push_back(64'h7FF8_0000_0000_0000);
        pending_words.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_words.push_back(64'h7FF0_0000_0000_0001);
        pending_words.push_back(64'h0000_0000_0000_0001);
        pending_words.push_back(64'h000F_FFFF_FFFF_FFFF);
        pending_words.push_back(64'h7FEF_FFFF_FFFF_FFFF);
        pending_words.push_back(64'h3FF0_0000_0000_0000);
        pending_words.push_back(64'hBFF8_0000_0000_0000);
        pending_words.push_back(64'h3FFF_FFFF_FFFF_FFFF);
        pending_words.push_back(64'h47EF_FFFF_F000_0000);
        pending_words.push_back(64'h47EF_FFFF_E000_0000);
        pending_words.push_back(64'h3810_0000_0000_0000);
        pending_words.push_back(64'h380F_FFFF_F000_0000);
        pending_words.push_back(64'h3690_0000_0000_0000);
        pending_words.push_back(64'h36A0_0000_0000_0000);
        pending_words.push_back(64'h3FF0_0000_1000_0000);
        pending_words.push_back(64'h3FF0_0000_3000_0000);
        pending_words.push_back(64'h5555_5555_5555_5555);
        pending_words.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            pending_words.push_back(random_word());
    endtask

    task automatic set_format(input int ew, input int mw);
        apb_write(d2mf_pkg::ADDR_EXP_WIDTH, 32'(ew));
        apb_write(d2mf_pkg::ADDR_MAN_WIDTH, 32'(mw));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset format (binary32 layout), sender idles lightly.
        send_idle_pct = 10;
        recv_idle_pct = 53;
        queue_directed();
        queue_random(250);
        wait_drained();

        set_format(2, 1);
        queue_directed();
        queue_random(250);
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 10;
        set_format(5, 10);
        queue_directed();
        queue_random(250);
        wait_drained();

        // Out-of-range values saturate to the limits.
        set_format(15, 31);
        queue_directed();
        queue_random(200);
        wait_drained();
        set_format(0, 0);
        queue_random(200);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_format(8, 23);
        queue_random(250);
        // Receiver holds off while the sender keeps offering words.
        recv_hold = 1'b1;
        repeat (60) @(posedge clk);
        recv_hold = 1'b0;
        wait_drained();

        set_format(3, 4);
        queue_random(350);
        wait_drained();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> double_to_minifloat_converter.f
hdl/d2mf_pkg.sv
hdl/d2mf_stream_if.sv
hdl/d2mf_core.sv
hdl/double_to_minifloat_converter.sv
hdl/d2mf_checker.sv
tb/tb_top.sv
